>>> rtl/core/time_token_parser_assert.svh
// ----------------------------------------------------------------------------
// time_token_parser_assert.svh
// Assertion macros for the time token parser.
// ----------------------------------------------------------------------------
`ifndef TIME_TOKEN_PARSER_ASSERT_SVH
`define TIME_TOKEN_PARSER_ASSERT_SVH

// same-cycle implication
`define TTP_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ttp_pkg.sv
// ----------------------------------------------------------------------------
// ttp_pkg
// Types, character codes and scaling constants of the time token parser.
// ----------------------------------------------------------------------------
package ttp_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [61:0] time_ns;
      logic [1:0]  error_code;
   } rsp_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_FRAC_LONG = 2'd1,
      ERR_FRAC_NONE = 2'd2,
      ERR_UNIT      = 2'd3
   } err_type;

   typedef enum logic [3:0] {
      UNIT_NS = 4'b0001,
      UNIT_S  = 4'b0010,
      UNIT_MS = 4'b0100,
      UNIT_US = 4'b1000
   } unit_type;

   typedef struct packed {
      logic [31:0] whole;
      logic [29:0] frac;
      logic [3:0]  digits;
      unit_type    unit;
      err_type     err;
   } tok_type;

   localparam logic [7:0] CH_0          = 8'h30;
   localparam logic [7:0] CH_9          = 8'h39;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_S          = 8'h73;
   localparam logic [7:0] CH_M          = 8'h6D;
   localparam logic [7:0] CH_U          = 8'h75;
   localparam logic [7:0] CH_N          = 8'h6E;
   localparam logic [7:0] CH_MICRO_LEAD = 8'hC2;
   localparam logic [7:0] CH_MICRO_TAIL = 8'hB5;

   localparam logic [3:0] FRAC_DIGITS_MAX  = 4'd9;
   localparam logic [3:0] FRAC_DIGITS_OVER = 4'd10;

   localparam logic [29:0] NS_PER_S  = 30'd1000000000;
   localparam logic [29:0] NS_PER_MS = 30'd1000000;
   localparam logic [29:0] NS_PER_US = 30'd1000;
   localparam logic [29:0] NS_PER_NS = 30'd1;

   // floor(x / 1000) and floor(x / 1000000) for x below 2^30
   localparam logic [30:0] RECIP_MS = 31'd1099511628;
   localparam logic [30:0] RECIP_US = 31'd1125899907;
   localparam int unsigned SHIFT_MS = 40;
   localparam int unsigned SHIFT_US = 50;

   function automatic logic [29:0] frac_scale(input logic [3:0] digits);
      logic [29:0] scale;
      case (digits)
         4'd0:    scale = 30'd1000000000;
         4'd1:    scale = 30'd100000000;
         4'd2:    scale = 30'd10000000;
         4'd3:    scale = 30'd1000000;
         4'd4:    scale = 30'd100000;
         4'd5:    scale = 30'd10000;
         4'd6:    scale = 30'd1000;
         4'd7:    scale = 30'd100;
         4'd8:    scale = 30'd10;
         default: scale = 30'd1;
      endcase
      return scale;
   endfunction

endpackage

>>> rtl/core/ttp_fifo.sv
// ----------------------------------------------------------------------------
// ttp_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module ttp_fifo #(
   parameter int unsigned DEPTH = ttp_pkg::QUEUE_DEPTH_DEF,
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[head_ff];

   always_comb begin
      head_in  = do_rd ? ptr_next(head_ff) : head_ff;
      tail_in  = do_wr ? ptr_next(tail_ff) : tail_ff;
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[tail_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/core/ttp_front.sv
// ----------------------------------------------------------------------------
// ttp_front
// Byte-wise token scanner: integer, fraction and unit suffix; classifies the
// finished token and hands it on as one record.
// ----------------------------------------------------------------------------
module ttp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  ttp_pkg::req_type  req_data,
   output logic              tok_push,
   output ttp_pkg::tok_type  tok_data
);

   typedef enum logic [3:0] {
      PH_INT     = 4'b0001,
      PH_FRAC    = 4'b0010,
      PH_SUF     = 4'b0100,
      PH_SUF_DOT = 4'b1000
   } phase_type;

   typedef enum logic [7:0] {
      SM_NS = 8'b0000_0001,
      SM_M  = 8'b0000_0010,
      SM_U  = 8'b0000_0100,
      SM_N  = 8'b0000_1000,
      SM_C2 = 8'b0001_0000,
      SM_S  = 8'b0010_0000,
      SM_MS = 8'b0100_0000,
      SM_US = 8'b1000_0000
   } match_type;

   logic [31:0] whole_ff, whole_in;
   logic [29:0] frac_ff, frac_in;
   logic [3:0]  digits_ff, digits_in;
   phase_type   phase_ff, phase_in;
   match_type   match_ff, match_in;
   logic        bad_ff, bad_in;

   logic [7:0]  c;
   logic        is_digit;
   logic [3:0]  digit_val;
   logic [35:0] whole_x10;
   logic [31:0] whole_sat;
   logic [32:0] frac_x10;
   logic        start_suffix, cont_suffix;
   logic        dot, in_suffix, partial;
   ttp_pkg::err_type  err;
   ttp_pkg::unit_type unit;

   assign c         = req_data.char_byte;
   assign is_digit  = (c >= ttp_pkg::CH_0) && (c <= ttp_pkg::CH_9);
   assign digit_val = c[3:0];
   assign whole_x10 = {1'b0, whole_ff, 3'b000} + {3'b000, whole_ff, 1'b0}
                    + {32'd0, digit_val};
   assign whole_sat = (|whole_x10[35:32]) ? '1 : whole_x10[31:0];
   assign frac_x10  = {frac_ff, 3'b000} + {2'b00, frac_ff, 1'b0} + {29'd0, digit_val};

   always_comb begin
      whole_in     = whole_ff;
      frac_in      = frac_ff;
      digits_in    = digits_ff;
      phase_in     = phase_ff;
      match_in     = match_ff;
      bad_in       = bad_ff;
      start_suffix = 1'b0;
      cont_suffix  = 1'b0;
      unique case (phase_ff)
         PH_INT: begin
            if (is_digit) begin
               whole_in = whole_sat;
            end else if (c == ttp_pkg::CH_DOT) begin
               phase_in = PH_FRAC;
            end else begin
               start_suffix = 1'b1;
            end
         end
         PH_FRAC: begin
            if (is_digit) begin
               if (digits_ff < ttp_pkg::FRAC_DIGITS_MAX) begin
                  frac_in   = frac_x10[29:0];
                  digits_in = digits_ff + 4'd1;
               end else begin
                  digits_in = ttp_pkg::FRAC_DIGITS_OVER;
               end
            end else begin
               start_suffix = 1'b1;
            end
         end
         PH_SUF, PH_SUF_DOT: begin
            cont_suffix = 1'b1;
         end
         default: begin
            phase_in = PH_INT;
         end
      endcase

      if (start_suffix) begin
         phase_in = (phase_ff == PH_FRAC) ? PH_SUF_DOT : PH_SUF;
         unique case (c)
            ttp_pkg::CH_S:          match_in = SM_S;
            ttp_pkg::CH_M:          match_in = SM_M;
            ttp_pkg::CH_U:          match_in = SM_U;
            ttp_pkg::CH_N:          match_in = SM_N;
            ttp_pkg::CH_MICRO_LEAD: match_in = SM_C2;
            default:                bad_in   = 1'b1;
         endcase
      end

      if (cont_suffix && !bad_ff) begin
         priority if (match_ff == SM_M && c == ttp_pkg::CH_S) begin
            match_in = SM_MS;
         end else if (match_ff == SM_U && c == ttp_pkg::CH_S) begin
            match_in = SM_US;
         end else if (match_ff == SM_N && c == ttp_pkg::CH_S) begin
            match_in = SM_NS;
         end else if (match_ff == SM_C2 && c == ttp_pkg::CH_MICRO_TAIL) begin
            match_in = SM_U;
         end else begin
            bad_in = 1'b1;
         end
      end
   end

   assign dot       = (phase_in == PH_FRAC) || (phase_in == PH_SUF_DOT);
   assign in_suffix = (phase_in == PH_SUF) || (phase_in == PH_SUF_DOT);
   assign partial   = (match_in == SM_M) || (match_in == SM_U) || (match_in == SM_N)
                   || (match_in == SM_C2);

   always_comb begin
      priority if (dot && digits_in > ttp_pkg::FRAC_DIGITS_MAX) begin
         err = ttp_pkg::ERR_FRAC_LONG;
      end else if (dot && digits_in == 4'd0) begin
         err = ttp_pkg::ERR_FRAC_NONE;
      end else if (in_suffix && (bad_in || partial)) begin
         err = ttp_pkg::ERR_UNIT;
      end else begin
         err = ttp_pkg::ERR_NONE;
      end
   end

   always_comb begin
      unit = ttp_pkg::UNIT_NS;
      if (in_suffix) begin
         unique case (match_in)
            SM_S:    unit = ttp_pkg::UNIT_S;
            SM_MS:   unit = ttp_pkg::UNIT_MS;
            SM_US:   unit = ttp_pkg::UNIT_US;
            default: unit = ttp_pkg::UNIT_NS;
         endcase
      end
   end

   assign tok_push        = accept && req_data.last_char;
   assign tok_data.whole  = whole_in;
   assign tok_data.frac   = frac_in;
   assign tok_data.digits = digits_in;
   assign tok_data.unit   = unit;
   assign tok_data.err    = err;

   always_ff @(posedge clock) begin
      if (reset || tok_push) begin
         whole_ff  <= '0;
         frac_ff   <= '0;
         digits_ff <= '0;
         phase_ff  <= PH_INT;
         match_ff  <= SM_NS;
         bad_ff    <= 1'b0;
      end else if (accept) begin
         whole_ff  <= whole_in;
         frac_ff   <= frac_in;
         digits_ff <= digits_in;
         phase_ff  <= phase_in;
         match_ff  <= match_in;
         bad_ff    <= bad_in;
      end
   end

endmodule

>>> rtl/core/ttp_back.sv
// ----------------------------------------------------------------------------
// ttp_back
// Two-stage scaling pipeline: integer and fraction to nanoseconds, unit
// reduction of the fraction, final sum.
// ----------------------------------------------------------------------------
module ttp_back (
   input  logic              clock,
   input  logic              reset,
   input  ttp_pkg::tok_type  tok_data,
   input  logic              tok_empty,
   output logic              tok_pop,
   output logic              rsp_push,
   output ttp_pkg::rsp_type  rsp_data,
   input  logic              rsp_full
);

   logic              adv;
   logic [29:0]       unit_scale;
   logic [61:0]       whole_prod;
   logic [59:0]       frac_prod;
   logic [30:0]       recip;
   logic [60:0]       recip_prod;
   logic [29:0]       frac_unit;

   logic              s1_valid_ff;
   logic [61:0]       s1_whole_ff;
   logic [29:0]       s1_frac_ff;
   ttp_pkg::unit_type s1_unit_ff;
   ttp_pkg::err_type  s1_err_ff;

   logic              s2_valid_ff;
   logic [61:0]       s2_whole_ff;
   logic [29:0]       s2_frac_ff;
   ttp_pkg::err_type  s2_err_ff;

   assign adv      = !s2_valid_ff || !rsp_full;
   assign tok_pop  = adv && !tok_empty;
   assign rsp_push = s2_valid_ff && !rsp_full;

   always_comb begin
      unique case (tok_data.unit)
         ttp_pkg::UNIT_S:  unit_scale = ttp_pkg::NS_PER_S;
         ttp_pkg::UNIT_MS: unit_scale = ttp_pkg::NS_PER_MS;
         ttp_pkg::UNIT_US: unit_scale = ttp_pkg::NS_PER_US;
         default:          unit_scale = ttp_pkg::NS_PER_NS;
      endcase
   end

   assign whole_prod = {30'd0, tok_data.whole} * {32'd0, unit_scale};
   assign frac_prod  = {30'd0, tok_data.frac} * {30'd0, ttp_pkg::frac_scale(tok_data.digits)};

   assign recip      = (s1_unit_ff == ttp_pkg::UNIT_MS) ? ttp_pkg::RECIP_MS : ttp_pkg::RECIP_US;
   assign recip_prod = {31'd0, s1_frac_ff} * {30'd0, recip};

   always_comb begin
      unique case (s1_unit_ff)
         ttp_pkg::UNIT_S:  frac_unit = s1_frac_ff;
         ttp_pkg::UNIT_MS: frac_unit = 30'(recip_prod[60:ttp_pkg::SHIFT_MS]);
         ttp_pkg::UNIT_US: frac_unit = 30'(recip_prod[60:ttp_pkg::SHIFT_US]);
         default:          frac_unit = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= !tok_empty;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_whole_ff <= whole_prod;
         s1_frac_ff  <= frac_prod[29:0];
         s1_unit_ff  <= tok_data.unit;
         s1_err_ff   <= tok_data.err;
         s2_whole_ff <= s1_whole_ff;
         s2_frac_ff  <= frac_unit;
         s2_err_ff   <= s1_err_ff;
      end
   end

   assign rsp_data.time_ns    = (s2_err_ff == ttp_pkg::ERR_NONE)
                              ? s2_whole_ff + {32'd0, s2_frac_ff} : '0;
   assign rsp_data.error_code = s2_err_ff;

endmodule

>>> rtl/core/time_token_parser.sv
// ----------------------------------------------------------------------------
// time_token_parser
// Parses a time token, one text byte per request, into nanoseconds.
// ----------------------------------------------------------------------------
// Requests enter through push/full with req_data (char_byte, last_char); a
// request is taken on a clock edge with push high and full low. One byte is
// taken per cycle while full is low. The byte flagged last_char closes the token
// and yields exactly one result; other bytes yield none.
// Results leave through empty/pop with rsp_data (time_ns, error_code); the
// oldest result is shown while empty is low and leaves on an edge with pop
// high. time_ns is zero whenever error_code is non-zero.
// A closed token passes from the token queue through the scaling multiply
// stage and the unit reduction stage into the result queue.
// Throughput: one byte per cycle while full is low, set by the byte scanner;
// the scaling pipeline takes one token per cycle unless the result queue stalls it.
// Synchronous reset empties both queues, clears the pipeline and returns the
// scanner to the start of a token. A stalled receiver fills the result queue,
// then the pipeline, then the token queue; full then rises.
// ----------------------------------------------------------------------------
module time_token_parser #(
   parameter int unsigned QUEUE_DEPTH = ttp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ttp_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output ttp_pkg::rsp_type rsp_data
);

   localparam int unsigned TOK_W = $bits(ttp_pkg::tok_type);
   localparam int unsigned RSP_W = $bits(ttp_pkg::rsp_type);

   logic             accept;
   logic             tok_push, tok_pop, tq_full, tq_empty;
   ttp_pkg::tok_type tok_wr, tok_rd;
   logic [TOK_W-1:0] tok_rd_bits;
   logic             oq_push, oq_full;
   ttp_pkg::rsp_type rsp_wr;
   logic [RSP_W-1:0] rsp_rd_bits;

   assign full   = tq_full;
   assign accept = push && !tq_full;

   ttp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .tok_push (tok_push),
      .tok_data (tok_wr)
   );

   ttp_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (TOK_W)
   ) u_tok_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tok_push),
      .wr_data (TOK_W'(tok_wr)),
      .full    (tq_full),
      .rd_en   (tok_pop),
      .rd_data (tok_rd_bits),
      .empty   (tq_empty)
   );

   assign tok_rd = ttp_pkg::tok_type'(tok_rd_bits);

   ttp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_data  (tok_rd),
      .tok_empty (tq_empty),
      .tok_pop   (tok_pop),
      .rsp_push  (oq_push),
      .rsp_data  (rsp_wr),
      .rsp_full  (oq_full)
   );

   ttp_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (RSP_W)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (oq_push),
      .wr_data (RSP_W'(rsp_wr)),
      .full    (oq_full),
      .rd_en   (pop),
      .rd_data (rsp_rd_bits),
      .empty   (empty)
   );

   assign rsp_data = ttp_pkg::rsp_type'(rsp_rd_bits);

`include "time_token_parser_assert.svh"

   `TTP_ASSERT_IMPLY(a_err_zero_time, clock, reset, (!empty && rsp_data.error_code != ttp_pkg::ERR_NONE), (rsp_data.time_ns == 62'd0), "errored result carries a non-zero time")
   `TTP_ASSERT_NEXT(a_last_queued, clock, reset, (accept && req_data.last_char), (!tq_empty), "closed token missing from token queue")
   `TTP_ASSERT_IMPLY(a_pop_nonempty, clock, reset, (tok_pop), (!tq_empty), "pipeline took from an empty token queue")

endmodule
